>>> rtl/assert_macros.svh
// Assertion helper macros shared by the queue, unit and back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)
`endif

>>> rtl/crs_pkg.sv
// Types and constants of the color region statistics block
`timescale 1ns / 1ps
package crs_pkg;

  // field widths
  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int CFG_W    = 13;
  localparam int COUNT_W  = 25;
  localparam int CSUM_W   = 32;
  localparam int CSQ_W    = 40;
  localparam int PSUM_W   = 36;
  localparam int PSQ_W    = 48;
  localparam int MEAN_CH_W = 16;
  localparam int MEAN_POS_W = 20;
  localparam int PCT_W    = 15;
  localparam int FRAC_BITS = 8;

  localparam int NUM_CH    = 3;
  localparam int NUM_POS   = 2;
  localparam int NUM_STATS = NUM_CH + NUM_POS;

  localparam logic [COUNT_W-1:0] MAX_POINTS = 25'h1000000;

  // selected share: 100 scaled to Q.8, saturation limit
  localparam logic [PCT_W-1:0] PCT_SCALE = 15'd25600;
  localparam logic [PCT_W-1:0] PCT_MAX   = 15'h7FFF;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 1'b1;

  // serial arithmetic unit
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 36;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIVD_W    = 90;
  localparam int DIVS_W    = 50;
  localparam int QUOT_W    = 40;
  localparam int ROOT_W    = QUOT_W / 2;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W    = 7;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // sums of one finished set
  typedef struct packed {
    logic [COUNT_W-1:0]               count;
    logic [NUM_CH-1:0][CSUM_W-1:0]    csum;
    logic [NUM_CH-1:0][CSQ_W-1:0]     csq;
    logic [NUM_POS-1:0][PSUM_W-1:0]   psum;
    logic [NUM_POS-1:0][PSQ_W-1:0]    psq;
  } set_sums_t;

  // one result beat
  typedef struct packed {
    logic [NUM_CH-1:0][MEAN_CH_W-1:0]   mean_ch;
    logic [NUM_CH-1:0][MEAN_CH_W-1:0]   std_ch;
    logic [NUM_POS-1:0][MEAN_POS_W-1:0] mean_pos;
    logic [NUM_POS-1:0][MEAN_POS_W-1:0] std_pos;
    logic [PCT_W-1:0]                   pct;
    logic [COUNT_W-1:0]                 count;
  } res_t;

endpackage

>>> rtl/crs_front.sv
// Front end: takes one point per cycle while the queue has room and accumulates the set sums
`timescale 1ns / 1ps
module crs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [crs_pkg::COORD_W-1:0] point_x,
  input  logic [crs_pkg::COORD_W-1:0] point_y,
  input  logic [crs_pkg::CHAN_W-1:0]  red_value,
  input  logic [crs_pkg::CHAN_W-1:0]  green_value,
  input  logic [crs_pkg::CHAN_W-1:0]  blue_value,
  input  logic                      last_point,
  output logic                      q_push,
  output crs_pkg::set_sums_t        q_data,
  input  logic                      q_full
);
  import crs_pkg::*;

  set_sums_t acc_r;
  set_sums_t acc_upd;
  logic      accept;
  logic [NUM_CH-1:0][CHAN_W-1:0]      chan;
  logic [NUM_CH-1:0][2*CHAN_W-1:0]    chan_sq;
  logic [NUM_POS-1:0][COORD_W-1:0]    pos;
  logic [NUM_POS-1:0][2*COORD_W-1:0]  pos_sq;

  // stall the whole set while the queue has no room
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // sums including this point; saturated sets ignore further points
  always_comb begin
    chan[0] = red_value;
    chan[1] = green_value;
    chan[2] = blue_value;
    pos[0]  = point_x;
    pos[1]  = point_y;
    acc_upd = acc_r;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_sq[i] = chan[i] * chan[i];
    end
    for (int i = 0; i < NUM_POS; i++) begin
      pos_sq[i] = pos[i] * pos[i];
    end
    if (acc_r.count < MAX_POINTS) begin
      acc_upd.count = acc_r.count + COUNT_W'(1);
      for (int i = 0; i < NUM_CH; i++) begin
        acc_upd.csum[i] = acc_r.csum[i] + CSUM_W'(chan[i]);
        acc_upd.csq[i]  = acc_r.csq[i] + CSQ_W'(chan_sq[i]);
      end
      for (int i = 0; i < NUM_POS; i++) begin
        acc_upd.psum[i] = acc_r.psum[i] + PSUM_W'(pos[i]);
        acc_upd.psq[i]  = acc_r.psq[i] + PSQ_W'(pos_sq[i]);
      end
    end
  end

  // last beat hands the finished set to the queue
  assign q_push = accept && last_point;
  assign q_data = acc_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      acc_r <= last_point ? '0 : acc_upd;
    end
  end

endmodule

>>> rtl/crs_fifo.sv
// Two-entry queue of finished set sums between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  crs_pkg::set_sums_t wdata,
  output logic               full,
  input  logic               pop,
  output crs_pkg::set_sums_t rdata,
  output logic               empty
);
  import crs_pkg::*;

  set_sums_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `ASSERT_NEVER(a_no_push_full, push && full && !pop, "queue written while full")
  `ASSERT_NEVER(a_no_pop_empty, pop && empty, "queue read while empty")

endmodule

>>> rtl/crs_unit.sv
// Shared serial unit: shift-add multiply, restoring divide, square root
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crs_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  crs_pkg::unit_req_t         req,
  input  logic [crs_pkg::DIVD_W-1:0] opa,
  input  logic [crs_pkg::DIVS_W-1:0] opb,
  output crs_pkg::unit_sts_t         sts,
  output logic [crs_pkg::PROD_W-1:0] prod,
  output logic [crs_pkg::QUOT_W-1:0] quot,
  output logic [crs_pkg::ROOT_W-1:0] root
);
  import crs_pkg::*;

  unit_op_t           op_r;
  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [PROD_W-1:0]  mcand_r;
  logic [MUL_B_W-1:0] mplier_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIVD_W-1:0]  dvd_r;
  logic [DIVS_W-1:0]  dvs_r;
  logic [DIVS_W-1:0]  rem_r;
  logic [QUOT_W-1:0]  quot_r;
  logic [QUOT_W-1:0]  sx_r;
  logic [QUOT_W-1:0]  root_r;
  logic [QUOT_W-1:0]  sbit_r;
  logic [DIVS_W:0]    rem_sh;
  logic               q_bit;
  logic [QUOT_W-1:0]  trial;

  // one divide digit and one root digit
  assign rem_sh = {rem_r, dvd_r[DIVD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_r});
  assign trial  = root_r + sbit_r;

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod = prod_r;
  assign quot = quot_r;
  assign root = root_r[ROOT_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        unique case (req.op)
          OP_MUL:  step_r <= STEP_W'(MUL_STEPS);
          OP_DIV:  step_r <= STEP_W'(DIV_STEPS);
          OP_SQRT: step_r <= STEP_W'(SQRT_STEPS);
          default: step_r <= STEP_W'(1);
        endcase
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r     <= req.op;
      mcand_r  <= PROD_W'(opa[MUL_A_W-1:0]);
      mplier_r <= opb[MUL_B_W-1:0];
      prod_r   <= '0;
      dvd_r    <= opa;
      dvs_r    <= opb;
      rem_r    <= '0;
      quot_r   <= '0;
      sx_r     <= opa[QUOT_W-1:0];
      root_r   <= '0;
      sbit_r   <= QUOT_W'(1) << (QUOT_W - 2);
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
        OP_DIV: begin
          rem_r  <= q_bit ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
          quot_r <= {quot_r[QUOT_W-2:0], q_bit};
          dvd_r  <= dvd_r << 1;
        end
        OP_SQRT: begin
          if (sx_r >= trial) begin
            sx_r   <= sx_r - trial;
            root_r <= (root_r >> 1) + sbit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_start_idle, req.start && busy_r, "unit started while busy")

endmodule

>>> rtl/crs_back.sv
// Back end: sequences means, deviations and share for each finished set
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  crs_pkg::set_sums_t         q_data,
  input  logic [crs_pkg::CFG_W-1:0]  img_width,
  input  logic [crs_pkg::CFG_W-1:0]  img_height,
  output crs_pkg::unit_req_t         req,
  output logic [crs_pkg::DIVD_W-1:0] opa,
  output logic [crs_pkg::DIVS_W-1:0] opb,
  input  crs_pkg::unit_sts_t         sts,
  input  logic [crs_pkg::PROD_W-1:0] prod,
  input  logic [crs_pkg::QUOT_W-1:0] quot,
  input  logic [crs_pkg::ROOT_W-1:0] root,
  output logic                       out_empty,
  input  logic                       out_pop,
  output crs_pkg::res_t              out_res
);
  import crs_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MEAN = 4'd1;
  localparam logic [3:0] ST_SQ1  = 4'd2;
  localparam logic [3:0] ST_SQ2  = 4'd3;
  localparam logic [3:0] ST_NN   = 4'd4;
  localparam logic [3:0] ST_VAR  = 4'd5;
  localparam logic [3:0] ST_ROOT = 4'd6;
  localparam logic [3:0] ST_AREA = 4'd7;
  localparam logic [3:0] ST_PCTM = 4'd8;
  localparam logic [3:0] ST_PCTD = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [2:0]        k_r, k_nxt;
  set_sums_t         snap_r, snap_nxt;
  res_t              work_r, work_nxt;
  logic [PROD_W-1:0] p1_r, p1_nxt;
  logic [PROD_W-1:0] dv_r, dv_nxt;
  logic [DIVS_W-1:0] area_r, area_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  // sum of statistic k: red, green, blue, then x, y
  function automatic logic [PSUM_W-1:0] sel_sum(set_sums_t s, logic [2:0] k);
    logic [PSUM_W-1:0] v;
    if (k < 3'(NUM_CH)) v = PSUM_W'(s.csum[k[1:0]]);
    else                v = s.psum[~k[0]];
    return v;
  endfunction

  function automatic logic [PSQ_W-1:0] sel_sq(set_sums_t s, logic [2:0] k);
    logic [PSQ_W-1:0] v;
    if (k < 3'(NUM_CH)) v = PSQ_W'(s.csq[k[1:0]]);
    else                v = s.psq[~k[0]];
    return v;
  endfunction

  // sum scaled to Q.8 as a dividend
  function automatic logic [DIVD_W-1:0] mean_dvd(set_sums_t s, logic [2:0] k);
    return DIVD_W'({sel_sum(s, k), {FRAC_BITS{1'b0}}});
  endfunction

  assign out_empty = !out_valid_r;
  assign out_res   = out_res_r;

  // sequencer: each wait state takes a unit result and starts any next op
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    snap_nxt      = snap_r;
    work_nxt      = work_r;
    p1_nxt        = p1_r;
    dv_nxt        = dv_r;
    area_nxt      = area_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    req.start     = 1'b0;
    req.op        = OP_MUL;
    opa           = '0;
    opb           = '0;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          snap_nxt       = q_data;
          work_nxt.count = q_data.count;
          k_nxt          = 3'd0;
          req.start      = 1'b1;
          req.op         = OP_DIV;
          opa            = mean_dvd(q_data, 3'd0);
          opb            = DIVS_W'(q_data.count);
          state_nxt      = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (sts.done) begin
          if (k_r < 3'(NUM_CH)) work_nxt.mean_ch[k_r[1:0]] = quot[MEAN_CH_W-1:0];
          else                  work_nxt.mean_pos[~k_r[0]] = quot[MEAN_POS_W-1:0];
          req.start = 1'b1;
          opa       = DIVD_W'(sel_sq(snap_r, k_r));
          opb       = DIVS_W'(snap_r.count);
          state_nxt = ST_SQ1;
        end
      end
      ST_SQ1: begin
        if (sts.done) begin
          p1_nxt    = prod;
          req.start = 1'b1;
          opa       = DIVD_W'(sel_sum(snap_r, k_r));
          opb       = DIVS_W'(sel_sum(snap_r, k_r));
          state_nxt = ST_SQ2;
        end
      end
      ST_SQ2: begin
        if (sts.done) begin
          dv_nxt    = p1_r - prod;
          req.start = 1'b1;
          opa       = DIVD_W'(snap_r.count);
          opb       = DIVS_W'(snap_r.count);
          state_nxt = ST_NN;
        end
      end
      ST_NN: begin
        // n*sumsq - sum^2 over n^2, scaled to Q.16
        if (sts.done) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          opa       = {dv_r[DIVD_W-2*FRAC_BITS-1:0], {(2*FRAC_BITS){1'b0}}};
          opb       = prod[DIVS_W-1:0];
          state_nxt = ST_VAR;
        end
      end
      ST_VAR: begin
        if (sts.done) begin
          req.start = 1'b1;
          req.op    = OP_SQRT;
          opa       = DIVD_W'(quot);
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sts.done) begin
          if (k_r < 3'(NUM_CH)) work_nxt.std_ch[k_r[1:0]] = root[MEAN_CH_W-1:0];
          else                  work_nxt.std_pos[~k_r[0]] = root;
          req.start = 1'b1;
          if (k_r == 3'(NUM_STATS - 1)) begin
            opa       = DIVD_W'(img_width);
            opb       = DIVS_W'(img_height);
            state_nxt = ST_AREA;
          end else begin
            k_nxt     = k_r + 3'd1;
            req.op    = OP_DIV;
            opa       = mean_dvd(snap_r, k_r + 3'd1);
            opb       = DIVS_W'(snap_r.count);
            state_nxt = ST_MEAN;
          end
        end
      end
      ST_AREA: begin
        if (sts.done) begin
          if (prod == '0) begin
            work_nxt.pct = '0;
            state_nxt    = ST_DONE;
          end else begin
            area_nxt  = prod[DIVS_W-1:0];
            req.start = 1'b1;
            opa       = DIVD_W'(snap_r.count);
            opb       = DIVS_W'(PCT_SCALE);
            state_nxt = ST_PCTM;
          end
        end
      end
      ST_PCTM: begin
        if (sts.done) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          opa       = DIVD_W'(prod);
          opb       = area_r;
          state_nxt = ST_PCTD;
        end
      end
      ST_PCTD: begin
        if (sts.done) begin
          work_nxt.pct = (quot > QUOT_W'(PCT_MAX)) ? PCT_MAX : quot[PCT_W-1:0];
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        // output register free: publish the result beat
        if (!out_valid_r) begin
          out_res_nxt   = work_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    snap_r    <= snap_nxt;
    work_r    <= work_nxt;
    p1_r      <= p1_nxt;
    dv_r      <= dv_nxt;
    area_r    <= area_nxt;
    out_res_r <= out_res_nxt;
  end

  `ASSERT_CLK(a_out_from_done, $rose(out_valid_r) |-> $past(state_r) == ST_DONE, "result without finished set")
  `ASSERT_CLK(a_pop_idle, q_pop |=> state_r == ST_MEAN, "set taken outside idle")

endmodule

>>> rtl/color_region_statistics.sv
// Top level of the color region statistics block
//
// Usage: selected points stream in on the in_ channel, one beat per cycle,
// through push/full. Each beat adds x, y and the red, green and blue values
// to the set sums; a beat with in_last_point high closes the set.
// One result beat per set leaves on the out_ channel through empty/pop:
// Q.8 means and deviations per color channel and per axis, the selected
// share of the image (100 * n / area, Q.8, saturated) and the point count.
// Each set's result is worked out step by step on the single shared serial
// unit: each of the five statistics takes a divide, three multiplies, a
// second divide and a root, and the share takes two multiplies and a
// divide.
// Points are taken at one per cycle; finished sets wait in a two-entry
// queue, and full rises only when that queue holds two waiting sets.
// A result that is not popped holds in the output register; the back end
// then stops, and the front keeps taking points until the queue fills.
// The cfg_ channel writes image width (index 0) and height (index 1) and
// is always ready. Reset clears the sums, the queue and the result, and
// sets the image size to 640 by 480.
`timescale 1ns / 1ps
module color_region_statistics (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [crs_pkg::COORD_W-1:0]       in_point_x,
  input  logic [crs_pkg::COORD_W-1:0]       in_point_y,
  input  logic [crs_pkg::CHAN_W-1:0]        in_red_value,
  input  logic [crs_pkg::CHAN_W-1:0]        in_green_value,
  input  logic [crs_pkg::CHAN_W-1:0]        in_blue_value,
  input  logic                              in_last_point,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [crs_pkg::MEAN_CH_W-1:0]     out_mean_red,
  output logic [crs_pkg::MEAN_CH_W-1:0]     out_mean_green,
  output logic [crs_pkg::MEAN_CH_W-1:0]     out_mean_blue,
  output logic [crs_pkg::MEAN_CH_W-1:0]     out_std_red,
  output logic [crs_pkg::MEAN_CH_W-1:0]     out_std_green,
  output logic [crs_pkg::MEAN_CH_W-1:0]     out_std_blue,
  output logic [crs_pkg::MEAN_POS_W-1:0]    out_mean_col,
  output logic [crs_pkg::MEAN_POS_W-1:0]    out_mean_row,
  output logic [crs_pkg::MEAN_POS_W-1:0]    out_std_col,
  output logic [crs_pkg::MEAN_POS_W-1:0]    out_std_row,
  output logic [crs_pkg::PCT_W-1:0]         out_selected_percent,
  output logic [crs_pkg::COUNT_W-1:0]       out_point_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crs_pkg::CFG_W-1:0]         cfg_data
);
  import crs_pkg::*;

  logic [CFG_W-1:0]  width_r;
  logic [CFG_W-1:0]  height_r;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  set_sums_t         q_wdata;
  set_sums_t         q_rdata;
  unit_req_t         req;
  unit_sts_t         sts;
  logic [DIVD_W-1:0] opa;
  logic [DIVS_W-1:0] opb;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [ROOT_W-1:0] root;
  res_t              res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd640;
      height_r <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMG_WIDTH:  width_r  <= cfg_data;
        CFG_IMG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  crs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .red_value   (in_red_value),
    .green_value (in_green_value),
    .blue_value  (in_blue_value),
    .last_point  (in_last_point),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  crs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  crs_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .sts   (sts),
    .prod  (prod),
    .quot  (quot),
    .root  (root)
  );

  crs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .img_width  (width_r),
    .img_height (height_r),
    .req        (req),
    .opa        (opa),
    .opb        (opb),
    .sts        (sts),
    .prod       (prod),
    .quot       (quot),
    .root       (root),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_res    (res)
  );

  // result fields
  assign out_mean_red         = res.mean_ch[0];
  assign out_mean_green       = res.mean_ch[1];
  assign out_mean_blue        = res.mean_ch[2];
  assign out_std_red          = res.std_ch[0];
  assign out_std_green        = res.std_ch[1];
  assign out_std_blue         = res.std_ch[2];
  assign out_mean_col         = res.mean_pos[0];
  assign out_mean_row         = res.mean_pos[1];
  assign out_std_col          = res.std_pos[0];
  assign out_std_row          = res.std_pos[1];
  assign out_selected_percent = res.pct;
  assign out_point_count      = res.count;

endmodule
